>>> src/kmx_pkg.sv
// Shared types, constants and pin table for the charlieplexed key scanner.
package kmx_pkg;

  localparam int ROWS = 4;
  localparam int COLS = 12;
  localparam int PINS = 14;

  localparam logic [7:0] SETTLE_RESET = 8'd10;

  typedef logic [PINS-1:0] pin_mask_t;
  typedef logic [COLS-1:0] row_bits_t;
  typedef logic [1:0]      row_idx_t;
  typedef logic [3:0]      col_idx_t;
  typedef logic [3:0]      pin_idx_t;
  typedef logic [7:0]      settle_t;

  typedef struct packed {
    pin_mask_t drive;
    pin_mask_t sense;
  } key_pins_t;

  typedef struct packed {
    pin_mask_t pin_levels;
    row_idx_t  query_row;
    col_idx_t  query_col;
  } request_t;

  typedef struct packed {
    pin_mask_t drive_high_mask;
    pin_mask_t pullup_mask;
    logic      row_done;
    row_idx_t  row_index;
    row_bits_t row_bits;
    logic      scan_done;
    logic      scan_changed;
    row_bits_t query_row_bits;
    logic      query_key_on;
  } result_t;

  // Sense pin per row, for even and odd columns.
  function automatic pin_idx_t sense_pin(input row_idx_t row, input logic odd);
    pin_idx_t p;
    p = '0;
    unique case (row)
      2'd0: p = odd ? 4'd12 : 4'd13;
      2'd1: p = odd ? 4'd10 : 4'd11;
      2'd2: p = odd ? 4'd7  : 4'd4;
      2'd3: p = odd ? 4'd9  : 4'd8;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic pin_mask_t pin_mask(input pin_idx_t p);
    pin_mask_t m;
    m = '0;
    if (32'(p) < PINS) m = pin_mask_t'(1) << p;
    return m;
  endfunction

endpackage

>>> src/kmx_if.sv
// Request and result channel interfaces of the key scanner.
interface kmx_in_if;
  import kmx_pkg::*;
  logic      valid;
  logic      ready;
  pin_mask_t pin_levels;
  row_idx_t  query_row;
  col_idx_t  query_col;
  modport source (output valid, pin_levels, query_row, query_col, input ready);
  modport sink   (input valid, pin_levels, query_row, query_col, output ready);
endinterface

interface kmx_out_if;
  import kmx_pkg::*;
  logic      valid;
  logic      ready;
  pin_mask_t drive_high_mask;
  pin_mask_t pullup_mask;
  logic      row_done;
  row_idx_t  row_index;
  row_bits_t row_bits;
  logic      scan_done;
  logic      scan_changed;
  row_bits_t query_row_bits;
  logic      query_key_on;
  modport source (output valid, drive_high_mask, pullup_mask, row_done, row_index,
                  row_bits, scan_done, scan_changed, query_row_bits, query_key_on,
                  input ready);
  modport sink   (input valid, drive_high_mask, pullup_mask, row_done, row_index,
                  row_bits, scan_done, scan_changed, query_row_bits, query_key_on,
                  output ready);
endinterface

>>> src/kmx_pin_decode.sv
// Key position to drive / sense pin masks.
module kmx_pin_decode (
  input  kmx_pkg::row_idx_t  row,
  input  kmx_pkg::col_idx_t  col,
  output kmx_pkg::key_pins_t pins
);
  import kmx_pkg::*;

  always_comb begin
    pins = '0;
    if (32'(row) < ROWS && 32'(col) < COLS) begin
      pins.drive = pin_mask({1'b0, col[3:1]});
      pins.sense = pin_mask(sense_pin(row, col[0]));
    end
  end
endmodule

>>> src/kmx_scan_ctrl.sv
// Scan state, row accumulation, publishing and query lookup.
module kmx_scan_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  kmx_pkg::settle_t cfg_wdata,
  input  logic             advance,
  input  kmx_pkg::request_t req,
  output kmx_pkg::result_t  res
);
  import kmx_pkg::*;

  settle_t   settle_ticks_r;
  row_idx_t  row_r, row_nxt;
  col_idx_t  col_r, col_nxt;
  settle_t   cnt_r, cnt_nxt;
  row_bits_t acc_r, acc_nxt;
  row_bits_t raw_r [ROWS];
  row_bits_t raw_nxt [ROWS];
  row_bits_t pub_r [ROWS];
  row_bits_t pub_nxt [ROWS];
  logic      chg_r, chg_nxt;

  row_idx_t  row_cur;
  col_idx_t  col_cur;
  key_pins_t pins;
  row_bits_t acc;

  always_comb begin
    row_cur = (32'(row_r) >= ROWS) ? '0 : row_r;
    col_cur = (32'(col_r) >= COLS) ? '0 : col_r;
  end

  kmx_pin_decode u_decode (
    .row  (row_cur),
    .col  (col_cur),
    .pins (pins)
  );

  always_comb begin
    row_nxt = row_cur;
    col_nxt = col_cur;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    raw_nxt = raw_r;
    pub_nxt = pub_r;
    chg_nxt = chg_r;
    acc     = acc_r;
    res     = '0;
    res.drive_high_mask = pins.drive;
    res.pullup_mask     = pins.sense;

    if (cnt_r < settle_ticks_r) begin
      cnt_nxt = cnt_r + 8'd1;
    end else begin
      cnt_nxt = '0;
      // low on the sense pin means the key is pressed
      if (pins.sense != '0 && (req.pin_levels & pins.sense) == '0) acc[col_cur] = 1'b1;
      if (32'(col_cur) + 1 >= COLS) begin
        res.row_done  = 1'b1;
        res.row_index = row_cur;
        res.row_bits  = acc;
        if (raw_r[row_cur] != acc) begin
          raw_nxt[row_cur] = acc;
          chg_nxt = 1'b1;
        end
        acc_nxt = '0;
        col_nxt = '0;
        if (32'(row_cur) + 1 >= ROWS) begin
          pub_nxt          = raw_nxt;
          res.scan_done    = 1'b1;
          res.scan_changed = chg_nxt;
          chg_nxt          = 1'b0;
          row_nxt          = '0;
        end else begin
          row_nxt = row_cur + 2'd1;
        end
      end else begin
        acc_nxt = acc;
        col_nxt = col_cur + 4'd1;
      end
    end

    // queries see this tick's publish
    if (32'(req.query_row) < ROWS) begin
      res.query_row_bits = pub_nxt[req.query_row];
      if (32'(req.query_col) < COLS) res.query_key_on = res.query_row_bits[req.query_col];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= SETTLE_RESET;
      row_r <= '0;
      col_r <= '0;
      cnt_r <= '0;
      acc_r <= '0;
      chg_r <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        raw_r[i] <= '0;
        pub_r[i] <= '0;
      end
    end else begin
      if (cfg_we) settle_ticks_r <= cfg_wdata;
      if (advance) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
        cnt_r <= cnt_nxt;
        acc_r <= acc_nxt;
        chg_r <= chg_nxt;
        raw_r <= raw_nxt;
        pub_r <= pub_nxt;
      end
    end
  end

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(col_r) < COLS)
    else $error("column counter out of range");

  a_publish_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.scan_done |=> !chg_r && row_r == '0 && col_r == '0)
    else $error("scan end did not restart scan");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cnt_r < settle_ticks_r |=> cnt_r == $past(cnt_r) + 8'd1)
    else $error("settle count did not advance");
endmodule

>>> src/charlieplex_key_matrix_scanner_core.sv
// Top level: request register, scan control and result register.
//
// Charlieplexed 4x12 key scanner over 14 pins. Each accepted request is one
// tick and yields exactly one result: the drive and pull-up masks of the key
// under scan, row/scan completion with the finished row bitmap and change
// flag, and the published bitmap and key bit selected by the query fields.
// A key is driven for cfg settle_ticks + 1 ticks (reset 10) and its sense
// pin, read from pin_levels, is sampled on the last one (low = pressed).
// Throughput is one request per clock while out_chan is not stalled; a
// taken request waits in the request register, and its result goes into
// the result register, one register stage on each side of the scan logic.
// settle_ticks may only be written while no request is in flight.
module charlieplex_key_matrix_scanner_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  kmx_pkg::settle_t cfg_wdata,
  kmx_in_if.sink           in_chan,
  kmx_out_if.source        out_chan
);
  import kmx_pkg::*;

  logic     req_valid_r;
  request_t req_r;
  logic     out_valid_r;
  result_t  out_r;
  result_t  res;
  logic     advance;
  logic     in_take;

  assign advance       = req_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !req_valid_r || advance;
  assign in_take       = in_chan.valid && in_chan.ready;

  kmx_scan_ctrl u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .req       (req_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take)      req_valid_r <= 1'b1;
      else if (advance) req_valid_r <= 1'b0;
      if (advance)              out_valid_r <= 1'b1;
      else if (out_chan.ready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.pin_levels <= in_chan.pin_levels;
      req_r.query_row  <= in_chan.query_row;
      req_r.query_col  <= in_chan.query_col;
    end
    if (advance) out_r <= res;
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.drive_high_mask = out_r.drive_high_mask;
  assign out_chan.pullup_mask     = out_r.pullup_mask;
  assign out_chan.row_done        = out_r.row_done;
  assign out_chan.row_index       = out_r.row_index;
  assign out_chan.row_bits        = out_r.row_bits;
  assign out_chan.scan_done       = out_r.scan_done;
  assign out_chan.scan_changed    = out_r.scan_changed;
  assign out_chan.query_row_bits  = out_r.query_row_bits;
  assign out_chan.query_key_on    = out_r.query_key_on;

  a_adv_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded");

  a_req_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r && !advance |=> req_valid_r)
    else $error("pending request lost");

  a_scan_is_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.scan_done |-> out_r.row_done && out_r.row_index == 2'(ROWS-1))
    else $error("scan end without last row");

  a_masks_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot(out_r.drive_high_mask) && $onehot(out_r.pullup_mask))
    else $error("pin masks not one-hot");
endmodule
